// File: hdl/apm_pkg.sv
// ----------------------------------------------------------------------------
// apm_pkg
// shared constants and the fractional log2 table for the peak level meter
// ----------------------------------------------------------------------------
package apm_pkg;

  // field widths of the fixed-size payload fields
  localparam int CH_W    = 4;
  localparam int DB_W    = 8;
  localparam int FINE_W  = 16;
  localparam int DECAY_W = 14;

  // result tdata: meter_channel, level_db, level_fine, zero pad to whole bytes
  localparam int MFIELD_W = CH_W + DB_W + FINE_W;
  localparam int MDATA_W  = ((MFIELD_W + 7) / 8) * 8;

  localparam logic [DECAY_W-1:0] DECAY_RESET = 14'd205;

  // q8.8 dB constants
  localparam logic signed [FINE_W-1:0] FLOOR_Q88 = -16'sd16384;
  localparam int OFFSET_Q88      = 1536;
  localparam int DB_PER_OCT_Q88  = 1541;
  localparam int ROUND_Q16       = 65535;
  localparam int MIN_LEVEL       = -32768;

  // log2 of (1 + f/16) scaled by 2^16; the caller subtracts it
  function automatic logic [15:0] frac_log2(input logic [3:0] f);
    logic [15:0] r;
    case (f)
      4'd0:    r = 16'd0;
      4'd1:    r = 16'd5732;
      4'd2:    r = 16'd11136;
      4'd3:    r = 16'd16248;
      4'd4:    r = 16'd21098;
      4'd5:    r = 16'd25711;
      4'd6:    r = 16'd30109;
      4'd7:    r = 16'd34312;
      4'd8:    r = 16'd38336;
      4'd9:    r = 16'd42196;
      4'd10:   r = 16'd45904;
      4'd11:   r = 16'd49472;
      4'd12:   r = 16'd52911;
      4'd13:   r = 16'd56229;
      4'd14:   r = 16'd59434;
      4'd15:   r = 16'd62534;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/apm_log_conv.sv
// ----------------------------------------------------------------------------
// apm_log_conv
// three-stage peak magnitude to q8.8 dBFS converter
// ----------------------------------------------------------------------------
module apm_log_conv #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [SAMPLE_BITS-1:0]            peak_i,
  output logic signed [apm_pkg::FINE_W-1:0] level_o
);
  import apm_pkg::*;

  localparam int NW     = $clog2(SAMPLE_BITS);
  localparam int M_W    = $clog2(SAMPLE_BITS + 1) + 16;
  localparam int PROD_W = M_W + 11;
  localparam int C_W    = PROD_W - 15;
  localparam int DBX_W  = C_W + 1;

  logic [NW-1:0]          n;
  logic [3:0]             f;
  logic [SAMPLE_BITS+3:0] pext;
  logic                   zero;
  logic [M_W-1:0]         m_d;

  logic [M_W-1:0]         m_q;
  logic                   zero_a_q;
  logic [PROD_W-1:0]      prod_q;
  logic                   zero_b_q;

  logic [PROD_W:0]            sum;
  logic [C_W-1:0]             c;
  logic signed [DBX_W-1:0]    db;
  logic signed [FINE_W-1:0]   level_d;
  logic signed [FINE_W-1:0]   level_q;

  // stage a: leading one, next four bits, table
  always_comb begin
    n = '0;
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      if (peak_i[i]) begin
        n = NW'(i);
      end
    end
    pext = {peak_i, 4'b0000};
    f    = pext[n +: 4];
    zero = (peak_i == '0);
    m_d  = {(M_W-16)'(SAMPLE_BITS - int'(n)), 16'd0} - M_W'(frac_log2(f));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q      <= m_d;
      zero_a_q <= zero;
    end
  end

  // stage b: scale octaves to dB
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= PROD_W'(m_q) * PROD_W'(DB_PER_OCT_Q88);
      zero_b_q <= zero_a_q;
    end
  end

  // stage c: ceil, offset, saturate
  always_comb begin
    sum = (PROD_W+1)'(prod_q) + (PROD_W+1)'(ROUND_Q16);
    c   = sum[PROD_W:16];
    db  = $signed(DBX_W'(OFFSET_Q88)) - $signed({1'b0, c});
    if (zero_b_q) begin
      level_d = FLOOR_Q88;
    end else if (db < MIN_LEVEL) begin
      level_d = FINE_W'(MIN_LEVEL);
    end else begin
      level_d = FINE_W'(db);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule

// File: hdl/audio_peak_level_meter.sv
// ----------------------------------------------------------------------------
// audio_peak_level_meter
// multichannel peak program meter with dBFS hold level and linear decay
// ----------------------------------------------------------------------------
// Takes one sample per clock, each tagged with a channel number; a channel
// number not below CHANNELS is accepted and dropped. Per-channel peak and
// held level live in two small synchronous memories (registered read) that
// are read, modified and written back with one-deep forwarding, so samples
// of the same channel may follow each other back to back. On a transfer
// with tlast set the peak is converted to q8.8 dBFS
// (6 + 20*log10(peak/2^SAMPLE_BITS), -64 dB for a zero peak), the held level
// decays by decay_step when above -64 dB and then rises to the new level if
// higher, and the channel, the whole-dB and the q8.8 held level pass through
// the stage 1 and 2 registers, the log conversion stages and the output
// register to m_axis_tdata. Throughput is one sample per cycle,
// bounded by the forwarded peak read-modify-write; the input only stalls
// while the two-entry output buffer is full. Reset takes effect at once:
// per-entry valid bits make never-written entries read as their reset
// values, so there is no clearing pass. The user writes decay_step through
// cfg_we_i/cfg_wdata_i only while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
module audio_peak_level_meter #(
  parameter int CHANNELS    = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config
  input  logic                               cfg_we_i,
  input  logic [apm_pkg::DECAY_W-1:0]        cfg_wdata_i,
  // sample input
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // channel [3:0], sample [SAMPLE_BITS+3:4], zero pad to whole bytes
  input  logic [((apm_pkg::CH_W+SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // period_end
  input  logic                               s_axis_tlast,
  // level output
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // meter_channel [3:0], level_db [11:4], level_fine [27:12], zero pad
  output logic [apm_pkg::MDATA_W-1:0]        m_axis_tdata
);
  import apm_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef struct packed {
    logic [CH_W-1:0]         ch;
    logic [DB_W-1:0]         whole;
    logic signed [FINE_W-1:0] fine;
  } result_t;

  // decay register
  logic [DECAY_W-1:0] decay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= DECAY_RESET;
    end else if (cfg_we_i) begin
      decay_q <= cfg_wdata_i;
    end
  end

  // pipeline advances unless the skid entry is occupied
  logic adv;
  logic skid_vld_q;
  logic out_vld_q;

  assign adv           = !skid_vld_q;
  assign s_axis_tready = !skid_vld_q;

  // ---------------- input decode (stage 0) ----------------
  logic                   in_xfer;
  logic [CH_W-1:0]        in_ch;
  logic [SAMPLE_BITS-1:0] in_smp;
  logic [SAMPLE_BITS-1:0] in_mag;
  logic                   in_range;

  always_comb begin
    in_xfer  = s_axis_tvalid && s_axis_tready;
    in_ch    = s_axis_tdata[CH_W-1:0];
    in_smp   = s_axis_tdata[CH_W +: SAMPLE_BITS];
    // two's complement magnitude; the most negative value maps to 2^(n-1)
    in_mag   = in_smp[SAMPLE_BITS-1] ? (~in_smp + 1'b1) : in_smp;
    in_range = (int'(in_ch) < CHANNELS);
  end

  // ---------------- peak memory ----------------
  logic [SAMPLE_BITS-1:0] peak_mem [CHANNELS];
  logic [CHANNELS-1:0]    peak_vld_q;
  logic [SAMPLE_BITS-1:0] peak_rd_q;
  logic                   peak_rd_vld_q;

  // stage 1 registers
  logic                   r1_vld_q;
  logic [CH_W-1:0]        r1_ch_q;
  logic [SAMPLE_BITS-1:0] r1_mag_q;
  logic                   r1_pe_q;

  // forward of the write made in the cycle of the read
  logic                   pfwd_vld_q;
  logic [AW-1:0]          pfwd_addr_q;
  logic [SAMPLE_BITS-1:0] pfwd_data_q;

  logic [AW-1:0]          r1_addr;
  logic [SAMPLE_BITS-1:0] peak_cur;
  logic [SAMPLE_BITS-1:0] peak_new;
  logic [SAMPLE_BITS-1:0] peak_wdata;
  logic                   peak_we;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      peak_rd_q     <= peak_mem[AW'(in_ch)];
      peak_rd_vld_q <= peak_vld_q[AW'(in_ch)];
      r1_ch_q       <= in_ch;
      r1_mag_q      <= in_mag;
      r1_pe_q       <= s_axis_tlast;
    end
  end

  always_comb begin
    r1_addr = AW'(r1_ch_q);
    if (pfwd_vld_q && (pfwd_addr_q == r1_addr)) begin
      peak_cur = pfwd_data_q;
    end else if (peak_rd_vld_q) begin
      peak_cur = peak_rd_q;
    end else begin
      peak_cur = '0;
    end
    peak_new   = (r1_mag_q > peak_cur) ? r1_mag_q : peak_cur;
    // period end clears the peak
    peak_wdata = r1_pe_q ? '0 : peak_new;
    peak_we    = adv && r1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (peak_we) begin
      peak_mem[r1_addr] <= peak_wdata;
    end
    if (adv) begin
      pfwd_addr_q <= r1_addr;
      pfwd_data_q <= peak_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_vld_q   <= 1'b0;
      pfwd_vld_q <= 1'b0;
      peak_vld_q <= '0;
    end else if (adv) begin
      r1_vld_q   <= in_xfer && in_range;
      pfwd_vld_q <= r1_vld_q;
      if (r1_vld_q) begin
        peak_vld_q[r1_addr] <= 1'b1;
      end
    end
  end

  // ---------------- stage 2 and log conversion ----------------
  // only period-end samples travel on past the peak update
  logic                   r2_vld_q, r3_vld_q, r4_vld_q, r5_vld_q;
  logic [CH_W-1:0]        r2_ch_q, r3_ch_q, r4_ch_q, r5_ch_q;
  logic [SAMPLE_BITS-1:0] r2_peak_q;
  logic signed [FINE_W-1:0] lvl;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r2_ch_q   <= r1_ch_q;
      r2_peak_q <= peak_new;
      r3_ch_q   <= r2_ch_q;
      r4_ch_q   <= r3_ch_q;
      r5_ch_q   <= r4_ch_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_vld_q <= 1'b0;
      r3_vld_q <= 1'b0;
      r4_vld_q <= 1'b0;
      r5_vld_q <= 1'b0;
    end else if (adv) begin
      r2_vld_q <= r1_vld_q && r1_pe_q;
      r3_vld_q <= r2_vld_q;
      r4_vld_q <= r3_vld_q;
      r5_vld_q <= r4_vld_q;
    end
  end

  // three register stages, level lines up with r5
  apm_log_conv #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_log (
    .clk_i  (clk_i),
    .en_i   (adv),
    .peak_i (r2_peak_q),
    .level_o(lvl)
  );

  // ---------------- held level memory ----------------
  logic signed [FINE_W-1:0] held_mem [CHANNELS];
  logic [CHANNELS-1:0]      held_vld_q;
  logic signed [FINE_W-1:0] held_rd_q;
  logic                     held_rd_vld_q;

  logic                     hfwd_vld_q;
  logic [AW-1:0]            hfwd_addr_q;
  logic signed [FINE_W-1:0] hfwd_data_q;

  logic [AW-1:0]            r5_addr;
  logic signed [FINE_W-1:0] held_cur;
  logic signed [FINE_W:0]   held_dec;
  logic signed [FINE_W-1:0] held_new;
  logic                     held_we;
  logic signed [FINE_W:0]   held_ext;
  logic [FINE_W:0]          held_abs;
  logic [DB_W:0]            whole_abs;
  logic [DB_W-1:0]          whole;

  // read issued one stage ahead of the update
  always_ff @(posedge clk_i) begin
    if (adv) begin
      held_rd_q     <= held_mem[AW'(r4_ch_q)];
      held_rd_vld_q <= held_vld_q[AW'(r4_ch_q)];
    end
  end

  always_comb begin
    r5_addr = AW'(r5_ch_q);
    if (hfwd_vld_q && (hfwd_addr_q == r5_addr)) begin
      held_cur = hfwd_data_q;
    end else if (held_rd_vld_q) begin
      held_cur = held_rd_q;
    end else begin
      held_cur = FLOOR_Q88;
    end
    // decay only while above the floor, then rise to the new level
    if (held_cur > FLOOR_Q88) begin
      held_dec = (FINE_W+1)'(held_cur) - $signed({3'b000, decay_q});
    end else begin
      held_dec = (FINE_W+1)'(held_cur);
    end
    if ((FINE_W+1)'(lvl) > held_dec) begin
      held_new = lvl;
    end else begin
      held_new = FINE_W'(held_dec);
    end
    held_we = adv && r5_vld_q;

    // whole dB, truncated toward zero
    held_ext  = (FINE_W+1)'(held_new);
    held_abs  = held_ext[FINE_W] ? (FINE_W+1)'(-held_ext) : (FINE_W+1)'(held_ext);
    whole_abs = held_abs[FINE_W:8];
    whole     = held_ext[FINE_W] ? DB_W'(~whole_abs + 1'b1) : DB_W'(whole_abs);
  end

  always_ff @(posedge clk_i) begin
    if (held_we) begin
      held_mem[r5_addr] <= held_new;
    end
    if (adv) begin
      hfwd_addr_q <= r5_addr;
      hfwd_data_q <= held_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hfwd_vld_q <= 1'b0;
      held_vld_q <= '0;
    end else if (adv) begin
      hfwd_vld_q <= r5_vld_q;
      if (r5_vld_q) begin
        held_vld_q[r5_addr] <= 1'b1;
      end
    end
  end

  // ---------------- output register and skid entry ----------------
  result_t res_d;
  result_t out_q;
  result_t skid_q;
  logic    res_vld;
  logic    out_xfer;

  always_comb begin
    res_d.ch    = r5_ch_q;
    res_d.whole = whole;
    res_d.fine  = held_new;
    res_vld     = adv && r5_vld_q;
    out_xfer    = out_vld_q && m_axis_tready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (out_xfer || !out_vld_q) begin
        if (skid_vld_q) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end else begin
          out_vld_q  <= res_vld;
        end
      end else if (res_vld) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_xfer || !out_vld_q) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (res_vld) begin
        out_q <= res_d;
      end
    end else if (res_vld) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid                          = out_vld_q;
  assign m_axis_tdata[CH_W-1:0]                 = out_q.ch;
  assign m_axis_tdata[CH_W +: DB_W]             = out_q.whole;
  assign m_axis_tdata[CH_W+DB_W +: FINE_W]      = out_q.fine;
  assign m_axis_tdata[MDATA_W-1:MFIELD_W]       = '0;

endmodule
